// ----- hdl/svd_pkg.sv -----
// shared types, constants and helper functions for the seven-segment value display
// no dependencies; used by every module of the block by scoped names
package svd_pkg;

  // field widths
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned LABEL_W  = 3;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned SEL_W    = 4;
  localparam int unsigned SEG_W    = 7;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned NFRAMES  = 5;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_PAD_W  = 4;

  // number mode switches from tenths layout to integer layout here
  localparam logic [VALUE_W-1:0] THRESHOLD = 16'd1000;

  // characters
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_O     = 8'h6F;

  // action codes
  localparam logic ACT_NUMBER = 1'b0;
  localparam logic ACT_TEXT   = 1'b1;

  // label range that adds a letter on digit 4
  localparam logic [LABEL_W-1:0] LABEL_MIN = 3'd1;
  localparam logic [LABEL_W-1:0] LABEL_MAX = 3'd5;

  // active-low digit selects
  localparam logic [SEL_W-1:0] SEL_D1 = 4'b1110;
  localparam logic [SEL_W-1:0] SEL_D2 = 4'b1101;
  localparam logic [SEL_W-1:0] SEL_D3 = 4'b1011;
  localparam logic [SEL_W-1:0] SEL_D4 = 4'b0111;

  // frame counts per layout
  localparam logic [COUNT_W-1:0] CNT_NUM_LOW  = 3'd4;
  localparam logic [COUNT_W-1:0] CNT_NUM_HIGH = 3'd3;
  localparam logic [COUNT_W-1:0] CNT_TEXT     = 3'd3;
  localparam logic [COUNT_W-1:0] CNT_MIN      = 3'd3;
  localparam logic [COUNT_W-1:0] CNT_MAX      = 3'd5;

  // reciprocal constants: x/10 == (x*52429)>>19 for x < 81920,
  // and (x*205)>>11 for x < 1029
  localparam logic [15:0] DIV10_MUL    = 16'd52429;
  localparam logic [7:0]  DIV10S_MUL   = 8'd205;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef struct packed {
    logic [SEL_W-1:0] sel;
    logic [SEG_W-1:0] segs;
    logic             dot;
  } svd_frame_t;

  typedef struct packed {
    logic [COUNT_W-1:0]           count;
    svd_frame_t [NFRAMES-1:0]     frames;
  } svd_entry_t;

  localparam svd_frame_t DOT_FRAME = '{sel: SEL_D2, segs: 7'h00, dot: 1'b1};

  // quotient by ten of a value up to 16 bits
  function automatic logic [12:0] div10(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(DIV10_MUL);
    return p[31:19];
  endfunction

  // quotient by ten of a small value (below 128)
  function automatic logic [3:0] div10_small(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'(DIV10S_MUL);
    return p[14:11];
  endfunction

  // remainder from value and its quotient by ten
  function automatic logic [DIGIT_W-1:0] rem10(input logic [15:0] x, input logic [12:0] q);
    logic [15:0] t;
    t = x - ({3'b000, q} << 3) - ({3'b000, q} << 1);
    return t[DIGIT_W-1:0];
  endfunction

  // segment pattern of a character, bit0 is segment a, dark when unknown
  function automatic logic [SEG_W-1:0] glyph(input logic [CHAR_W-1:0] c);
    logic [SEG_W-1:0] g;
    unique case (c)
      8'h30:   g = 7'h3F;
      8'h31:   g = 7'h06;
      8'h32:   g = 7'h5B;
      8'h33:   g = 7'h4F;
      8'h34:   g = 7'h66;
      8'h35:   g = 7'h6D;
      8'h36:   g = 7'h7D;
      8'h37:   g = 7'h07;
      8'h38:   g = 7'h7F;
      8'h39:   g = 7'h6F;
      8'h61:   g = 7'h77;
      8'h62:   g = 7'h7C;
      8'h63:   g = 7'h39;
      8'h64:   g = 7'h5E;
      8'h65:   g = 7'h79;
      8'h66:   g = 7'h71;
      CHAR_O:  g = 7'h5C;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

  // pattern of a decimal digit
  function automatic logic [SEG_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    return glyph(ASCII_ZERO + CHAR_W'(d));
  endfunction

endpackage

// ----- hdl/seven_segment_value_display_top.sv -----
// top level of the seven-segment value display: request stream in, frame stream out
// depends on svd_pkg, svd_front, svd_queue and svd_back
//
// Each request on the in_ stream turns into a run of three to five display frames on
// the out_ stream, the final one marked by out_tlast. A number request (in_tuser 0)
// gives hundreds, tens, a dot frame and units when the value is below 1000, else
// thousands mod 10, hundreds and tens; a text request (in_tuser 1) gives its three
// characters, dark where a character has no glyph; labels 1 to 5 add a letter a to e
// on digit 4. Frames leave at one per cycle while out_tready is high, from the back
// sequencer's single output register. A request taken into stage 1 passes stages 2
// and 3, the queue write and the output register before it reaches the output; the
// front keeps taking requests while up to two frame lists wait in the queue, so the
// output runs without gaps when requests arrive back to back.
module seven_segment_value_display_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // request stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [svd_pkg::IN_DATA_W-1:0]      in_tdata,  // value[15:0], label[18:16],
                                                        // text_first[26:19],
                                                        // text_second[34:27],
                                                        // text_third[42:35], zeros above
  input  logic                               in_tuser,  // action: 0 number, 1 text
  // frame stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [svd_pkg::OUT_DATA_W-1:0]     out_tdata, // digit_select[3:0], segments[10:4],
                                                        // dot[11], zeros above
  output logic                               out_tlast  // final frame of the request
);

  // front to queue
  logic                 fq_valid, fq_ready;
  svd_pkg::svd_entry_t  fq_data;
  // queue to back
  logic                 qb_valid, qb_pop;
  svd_pkg::svd_entry_t  qb_data;
  // output frame
  svd_pkg::svd_frame_t  frame;

  // accept and split into digits, build the frame list
  svd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_action      (in_tuser),
    .in_value       (in_tdata[15:0]),
    .in_label       (in_tdata[18:16]),
    .in_text_first  (in_tdata[26:19]),
    .in_text_second (in_tdata[34:27]),
    .in_text_third  (in_tdata[42:35]),
    .ent_valid      (fq_valid),
    .ent_ready      (fq_ready),
    .ent_data       (fq_data)
  );

  // lets the front run ahead of a stalled output
  svd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_pop),
    .rd_data  (qb_data)
  );

  // one frame per cycle into the output register while the output is not stalled
  svd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (qb_valid),
    .ent_pop   (qb_pop),
    .ent_data  (qb_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_frame (frame),
    .out_last  (out_tlast)
  );

  // pack the frame, select in the low bits
  assign out_tdata = {{svd_pkg::OUT_PAD_W{1'b0}}, frame.dot, frame.segs, frame.sel};

endmodule

// ----- hdl/svd_front.sv -----
// front part: accepts requests, splits the value into decimal digits over three
// stages and builds the frame list of each request; uses svd_pkg
module svd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [svd_pkg::VALUE_W-1:0]   in_value,
  input  logic [svd_pkg::LABEL_W-1:0]   in_label,
  input  logic [svd_pkg::CHAR_W-1:0]    in_text_first,
  input  logic [svd_pkg::CHAR_W-1:0]    in_text_second,
  input  logic [svd_pkg::CHAR_W-1:0]    in_text_third,
  output logic                          ent_valid,
  input  logic                          ent_ready,
  output svd_pkg::svd_entry_t           ent_data
);

  // stage 1: units digit and value/10
  logic                               s1_v_r;
  logic                               s1_action_r;
  logic                               s1_low_r;
  logic [svd_pkg::LABEL_W-1:0]        s1_label_r;
  logic [svd_pkg::CHAR_W-1:0]         s1_t1_r, s1_t2_r, s1_t3_r;
  logic [12:0]                        s1_q_r;
  logic [svd_pkg::DIGIT_W-1:0]        s1_d0_r;

  // stage 2: tens digit and value/100
  logic                               s2_v_r;
  logic                               s2_action_r;
  logic                               s2_low_r;
  logic [svd_pkg::LABEL_W-1:0]        s2_label_r;
  logic [svd_pkg::CHAR_W-1:0]         s2_t1_r, s2_t2_r, s2_t3_r;
  logic [9:0]                         s2_q_r;
  logic [svd_pkg::DIGIT_W-1:0]        s2_d0_r, s2_d1_r;

  // stage 3: hundreds digit and value/1000
  logic                               s3_v_r;
  logic                               s3_action_r;
  logic                               s3_low_r;
  logic [svd_pkg::LABEL_W-1:0]        s3_label_r;
  logic [svd_pkg::CHAR_W-1:0]         s3_t1_r, s3_t2_r, s3_t3_r;
  logic [6:0]                         s3_q_r;
  logic [svd_pkg::DIGIT_W-1:0]        s3_d0_r, s3_d1_r, s3_d2_r;

  logic adv1, adv2, adv3;
  logic [12:0] q1, q2, q3;
  logic [3:0]  q4;
  logic [svd_pkg::DIGIT_W-1:0] d3;
  svd_pkg::svd_entry_t ent;
  logic [svd_pkg::CHAR_W-1:0] label_char;

  assign adv3     = !s3_v_r || ent_ready;
  assign adv2     = !s2_v_r || adv3;
  assign adv1     = !s1_v_r || adv2;
  assign in_ready = adv1;

  assign q1 = svd_pkg::div10(in_value);
  assign q2 = svd_pkg::div10(16'(s1_q_r));
  assign q3 = svd_pkg::div10(16'(s2_q_r));
  assign q4 = svd_pkg::div10_small(s3_q_r);
  assign d3 = svd_pkg::rem10(16'(s3_q_r), 13'(q4));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_valid;
      if (adv2) s2_v_r <= s1_v_r;
      if (adv3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_action_r <= in_action;
      s1_low_r    <= (in_value < svd_pkg::THRESHOLD);
      s1_label_r  <= in_label;
      s1_t1_r     <= in_text_first;
      s1_t2_r     <= in_text_second;
      s1_t3_r     <= in_text_third;
      s1_q_r      <= q1;
      s1_d0_r     <= svd_pkg::rem10(in_value, q1);
    end
    if (adv2 && s1_v_r) begin
      s2_action_r <= s1_action_r;
      s2_low_r    <= s1_low_r;
      s2_label_r  <= s1_label_r;
      s2_t1_r     <= s1_t1_r;
      s2_t2_r     <= s1_t2_r;
      s2_t3_r     <= s1_t3_r;
      s2_q_r      <= q2[9:0];
      s2_d0_r     <= s1_d0_r;
      s2_d1_r     <= svd_pkg::rem10(16'(s1_q_r), q2);
    end
    if (adv3 && s2_v_r) begin
      s3_action_r <= s2_action_r;
      s3_low_r    <= s2_low_r;
      s3_label_r  <= s2_label_r;
      s3_t1_r     <= s2_t1_r;
      s3_t2_r     <= s2_t2_r;
      s3_t3_r     <= s2_t3_r;
      s3_q_r      <= q3[6:0];
      s3_d0_r     <= s2_d0_r;
      s3_d1_r     <= s2_d1_r;
      s3_d2_r     <= svd_pkg::rem10(16'(s2_q_r), q3);
    end
  end

  // frame list of the request in stage 3
  always_comb begin
    ent        = '0;
    label_char = svd_pkg::CHAR_A + svd_pkg::CHAR_W'(s3_label_r) - 8'd1;
    if (s3_action_r == svd_pkg::ACT_TEXT) begin
      ent.frames[0] = '{sel: svd_pkg::SEL_D3, segs: svd_pkg::glyph(s3_t1_r), dot: 1'b0};
      ent.frames[1] = '{sel: svd_pkg::SEL_D2, segs: svd_pkg::glyph(s3_t2_r), dot: 1'b0};
      ent.frames[2] = '{sel: svd_pkg::SEL_D1, segs: svd_pkg::glyph(s3_t3_r), dot: 1'b0};
      ent.count     = svd_pkg::CNT_TEXT;
    end else if (s3_low_r) begin
      // hundreds, tens, dot, units
      ent.frames[0] = '{sel: svd_pkg::SEL_D3, segs: svd_pkg::digit_glyph(s3_d2_r), dot: 1'b0};
      ent.frames[1] = '{sel: svd_pkg::SEL_D2, segs: svd_pkg::digit_glyph(s3_d1_r), dot: 1'b0};
      ent.frames[2] = svd_pkg::DOT_FRAME;
      ent.frames[3] = '{sel: svd_pkg::SEL_D1, segs: svd_pkg::digit_glyph(s3_d0_r), dot: 1'b0};
      ent.count     = svd_pkg::CNT_NUM_LOW;
    end else begin
      // thousands mod 10, hundreds, tens
      ent.frames[0] = '{sel: svd_pkg::SEL_D3, segs: svd_pkg::digit_glyph(d3), dot: 1'b0};
      ent.frames[1] = '{sel: svd_pkg::SEL_D2, segs: svd_pkg::digit_glyph(s3_d2_r), dot: 1'b0};
      ent.frames[2] = '{sel: svd_pkg::SEL_D1, segs: svd_pkg::digit_glyph(s3_d1_r), dot: 1'b0};
      ent.count     = svd_pkg::CNT_NUM_HIGH;
    end
    if (s3_label_r >= svd_pkg::LABEL_MIN && s3_label_r <= svd_pkg::LABEL_MAX) begin
      ent.frames[ent.count] = '{sel: svd_pkg::SEL_D4, segs: svd_pkg::glyph(label_char),
                                dot: 1'b0};
      ent.count = ent.count + 3'd1;
    end
  end

  assign ent_valid = s3_v_r;
  assign ent_data  = ent;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    ent_valid |-> (ent_data.count >= svd_pkg::CNT_MIN && ent_data.count <= svd_pkg::CNT_MAX))
    else $error("frame count out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !ent_ready) |=> (s3_v_r && $stable(s3_q_r) && $stable(s3_d2_r)))
    else $error("stage 3 changed while stalled");

endmodule

// ----- hdl/svd_queue.sv -----
// two-entry queue of frame lists between front and back
// uses svd_pkg for the entry type and depth
module svd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  svd_pkg::svd_entry_t  wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output svd_pkg::svd_entry_t  rd_data
);

  svd_pkg::svd_entry_t              mem_r [svd_pkg::QDEPTH];
  logic [svd_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [svd_pkg::QCNT_W-1:0]       cnt_r;
  logic                             push, pop;

  function automatic logic [svd_pkg::QCNT_W-1:0] QCNT_INC(input logic b);
    return {{(svd_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  assign wr_ready = (cnt_r != svd_pkg::QCNT_W'(svd_pkg::QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + QCNT_INC(push) - QCNT_INC(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= svd_pkg::QCNT_W'(svd_pkg::QDEPTH))
    else $error("queue count overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers apart while empty");

endmodule

// ----- hdl/svd_back.sv -----
// back part: walks the frame list at the queue head one frame per cycle, while the
// output is not stalled, into the output register; uses svd_pkg
module svd_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              ent_valid,
  output logic                              ent_pop,
  input  svd_pkg::svd_entry_t               ent_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output svd_pkg::svd_frame_t               out_frame,
  output logic                              out_last
);

  logic [svd_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                       out_v_r, out_v_nxt;
  svd_pkg::svd_frame_t        frame_r;
  logic                       last_r;
  logic                       load, take, is_last;

  assign load    = !out_v_r || out_ready;
  assign take    = load && ent_valid;
  assign is_last = (idx_r == ent_data.count - 3'd1);

  always_comb begin
    idx_nxt   = idx_r;
    ent_pop   = 1'b0;
    out_v_nxt = out_v_r && !out_ready;
    if (take) begin
      out_v_nxt = 1'b1;
      if (is_last) begin
        idx_nxt = '0;
        ent_pop = 1'b1;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame_r <= ent_data.frames[idx_r];
      last_r  <= is_last;
    end
  end

  assign out_valid = out_v_r;
  assign out_frame = frame_r;
  assign out_last  = last_r;

  a_idx_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    ent_valid |-> (idx_r < ent_data.count))
    else $error("frame index past end of list");

  a_mid_list_held: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> ent_valid)
    else $error("list left the queue head before its last frame");

endmodule
